### rtl/core/rdpd_pkg.sv
// Shared types, codes and helpers for the remote debug packet deframer.
package rdpd_pkg;

  // Frame phase codes
  localparam logic [1:0] PH_HUNT     = 2'd0;
  localparam logic [1:0] PH_PAYLOAD  = 2'd1;
  localparam logic [1:0] PH_CHK_HIGH = 2'd2;
  localparam logic [1:0] PH_CHK_LOW  = 2'd3;

  // Frame status codes on the result channel
  localparam logic [1:0] ST_HELD     = 2'd0;
  localparam logic [1:0] ST_SKIPPED  = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  // Framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // Configuration register indexes
  localparam logic REG_MAX_PAYLOAD = 1'b0;
  localparam logic REG_NO_ACK      = 1'b1;

  localparam int unsigned OUT_LEN_W = 16;

  typedef struct packed {
    logic [15:0] max_payload;
    logic        nack_disable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           frame_status;
    logic                 nack_req;
    logic [OUT_LEN_W-1:0] payload_length;
    logic [7:0]           payload_byte;
    logic                 payload_valid;
  } result_t;

  // Hex character to value; bit 4 set for a non-hex character
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = {1'b0, 4'(c - CH_ZERO)};
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = {1'b0, 4'(c - CH_LA + 8'd10)};
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = {1'b0, 4'(c - CH_UA + 8'd10)};
    end
    return v;
  endfunction

endpackage

### rtl/core/rdpd_cfg_regs.sv
// APB-style configuration registers of the packet deframer.
module rdpd_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rdpd_pkg::cfg_t      cfg
);

  logic [15:0] max_payload_r;
  logic        no_ack_r;
  logic        wr_en;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= 16'd4096;
      no_ack_r      <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        rdpd_pkg::REG_MAX_PAYLOAD: max_payload_r <= pwdata[15:0];
        rdpd_pkg::REG_NO_ACK:      no_ack_r      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      rdpd_pkg::REG_MAX_PAYLOAD: prdata = {16'd0, max_payload_r};
      rdpd_pkg::REG_NO_ACK:      prdata = {31'd0, no_ack_r};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg.max_payload  = max_payload_r;
  assign cfg.nack_disable = no_ack_r;

endmodule

### rtl/core/rdpd_step.sv
// Per-byte deframing step: next frame state and result for one byte.
module rdpd_step #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic [7:0]              data_byte,
  input  rdpd_pkg::cfg_t          cfg,
  input  logic [1:0]              phase,
  input  logic [LENGTH_WIDTH-1:0] count,
  input  logic [7:0]              sum,
  input  logic [4:0]              first_digit,
  output logic [1:0]              phase_nxt,
  output logic [LENGTH_WIDTH-1:0] count_nxt,
  output logic [7:0]              sum_nxt,
  output logic [4:0]              first_digit_nxt,
  output rdpd_pkg::result_t       res
);

  localparam int unsigned CMP_W =
    (LENGTH_WIDTH > rdpd_pkg::OUT_LEN_W) ? LENGTH_WIDTH : rdpd_pkg::OUT_LEN_W;

  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] max_ext;
  logic             over;
  logic [4:0]       digit;
  logic             sum_ok;

  assign count_ext = CMP_W'(count);
  assign max_ext   = CMP_W'(cfg.max_payload);
  assign over      = (count_ext >= max_ext) || (count == {LENGTH_WIDTH{1'b1}});
  assign digit     = rdpd_pkg::hex_digit(data_byte);
  assign sum_ok    = !first_digit[4] && !digit[4] &&
                     ({first_digit[3:0], digit[3:0]} == sum);

  always_comb begin
    phase_nxt           = phase;
    count_nxt           = count;
    sum_nxt             = sum;
    first_digit_nxt     = first_digit;
    res.frame_status    = rdpd_pkg::ST_HELD;
    res.payload_length  = '0;
    res.payload_byte    = 8'd0;
    res.payload_valid   = 1'b0;

    case (phase)
      rdpd_pkg::PH_HUNT: begin
        if (data_byte == rdpd_pkg::CH_DOLLAR) begin
          phase_nxt       = rdpd_pkg::PH_PAYLOAD;
          count_nxt       = '0;
          sum_nxt         = 8'd0;
          first_digit_nxt = 5'd0;
        end else begin
          res.frame_status = rdpd_pkg::ST_SKIPPED;
        end
      end
      rdpd_pkg::PH_PAYLOAD: begin
        if (data_byte == rdpd_pkg::CH_HASH) begin
          phase_nxt = rdpd_pkg::PH_CHK_HIGH;
        end else if (data_byte == rdpd_pkg::CH_DOLLAR) begin
          // restart: this byte opens a fresh frame
          res.frame_status = rdpd_pkg::ST_REJECTED;
          phase_nxt        = rdpd_pkg::PH_PAYLOAD;
          count_nxt        = '0;
          sum_nxt          = 8'd0;
          first_digit_nxt  = 5'd0;
        end else if (over) begin
          res.frame_status = rdpd_pkg::ST_REJECTED;
          phase_nxt        = rdpd_pkg::PH_HUNT;
        end else begin
          count_nxt         = count + 1'b1;
          sum_nxt           = sum + data_byte;
          res.payload_byte  = data_byte;
          res.payload_valid = 1'b1;
        end
      end
      rdpd_pkg::PH_CHK_HIGH: begin
        first_digit_nxt = digit;
        phase_nxt       = rdpd_pkg::PH_CHK_LOW;
      end
      rdpd_pkg::PH_CHK_LOW: begin
        if (sum_ok) begin
          res.frame_status   = rdpd_pkg::ST_COMPLETE;
          res.payload_length = count_ext[rdpd_pkg::OUT_LEN_W-1:0];
        end else begin
          res.frame_status = rdpd_pkg::ST_REJECTED;
        end
        phase_nxt = rdpd_pkg::PH_HUNT;
      end
      default: begin
        phase_nxt = rdpd_pkg::PH_HUNT;
      end
    endcase

    res.nack_req = (res.frame_status == rdpd_pkg::ST_REJECTED) && !cfg.nack_disable;
  end

endmodule

### rtl/core/remote_debug_packet_deframer_core.sv
// Remote debug packet deframer: '$' payload '#' hh framing on a byte stream.
// Path: a byte taken at the input is held in the input register, and its
// result sits in the result register when out_valid rises; out_stall holds both.
// Throughput: one byte per cycle while no out_stall holds the result; input
// register, one compare/add step on the frame state, then the result register.
// Reset (rst_n, synchronous): hunting for '$', count and sum cleared,
// max_payload 4096, nack disable 0, both channels empty.
module remote_debug_packet_deframer_core #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_status,
  output logic        out_nack_req,
  output logic [15:0] out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_valid,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rdpd_pkg::cfg_t          cfg;
  rdpd_pkg::result_t       res;
  rdpd_pkg::result_t       res_r;

  logic                    in_valid_r;
  logic [7:0]              byte_r;
  logic                    out_valid_r;
  logic                    adv;
  logic                    in_take;

  logic [1:0]              phase_r,  phase_nxt;
  logic [LENGTH_WIDTH-1:0] count_r,  count_nxt;
  logic [7:0]              sum_r,    sum_nxt;
  logic [4:0]              digit_r,  digit_nxt;

  rdpd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rdpd_step #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_step (
    .data_byte       (byte_r),
    .cfg             (cfg),
    .phase           (phase_r),
    .count           (count_r),
    .sum             (sum_r),
    .first_digit     (digit_r),
    .phase_nxt       (phase_nxt),
    .count_nxt       (count_nxt),
    .sum_nxt         (sum_nxt),
    .first_digit_nxt (digit_nxt),
    .res             (res)
  );

  // Pipeline moves when the result register is free or being drained
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv || !in_valid_r) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_data_byte;
    end
  end

  // Frame state, updated once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rdpd_pkg::PH_HUNT;
      count_r <= '0;
      sum_r   <= 8'd0;
      digit_r <= 5'd0;
    end else if (in_valid_r && adv) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      digit_r <= digit_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && adv) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_status   = res_r.frame_status;
  assign out_nack_req       = res_r.nack_req;
  assign out_payload_length = res_r.payload_length;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_payload_valid  = res_r.payload_valid;

endmodule
